// ===== rtl/core/ttu_pkg.sv =====
// ----------------------------------------------------------------------------
// ttu_pkg: shared types and constants for the triangle tangent unit
// Holds the sequencer state type, the field widths and the fixed-point
// constants that the datapath uses.
// ----------------------------------------------------------------------------
`default_nettype none

package ttu_pkg;

  // Default width of a vertex index inside the mesh.
  localparam int unsigned INDEX_BITS_DEF = 16;

  // Width of the index fields on the ports.
  localparam int unsigned IDX_W = 16;

  // Unit length in Q1.14.
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  // Input corner codes.
  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;
  // Corner code that the block ignores.
  localparam logic [1:0] CORNER_SKIP = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_MUL_ACC,
    ST_MUL_NEXT,
    ST_NORM,
    ST_SQ_LOAD,
    ST_SQ_RUN,
    ST_SQ_ACC,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_END,
    ST_DONE
  } ttu_state_t;

endpackage : ttu_pkg

`default_nettype wire

// ===== rtl/core/triangle_tangent_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_unit: per-triangle tangent from positions and UVs
// Collects three corners, forms edges and UV deltas, and produces the
// normalized tangent in Q1.14 together with the three vertex indices.
// ----------------------------------------------------------------------------
`default_nettype none

// Corners 0 and 1 are only held. When compute_enable is set, corner 2 starts
// a sequence that works on one triangle at a time; input stays stalled until
// it finishes. All products pass through one shift-and-add multiplier that
// retires one multiplier bit per cycle (eight products for the determinant
// and the tangent, then three squares). The length comes from a square root
// unit taking two radicand bits per cycle, and each of the three components
// from a restoring divider taking one quotient bit per cycle. Before the
// squares, the components are shifted right one bit per cycle until they fit
// in 31 bits. A zero determinant finishes after the first two products and a
// zero vector after all eight. A finished result waits in the output
// register while new corners are accepted; if that register is still full,
// the sequence waits for it.
module triangle_tangent_unit
  import ttu_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Configuration: bit 0 is compute_enable.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_data,
  // Input corners.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: vertex_index[15:0], pos_x[47:16], pos_y[79:48], pos_z[111:80],
  //        tex_u[143:112], tex_v[175:144]
  input  wire logic [175:0] in_tdata,
  // tuser: corner[1:0]
  input  wire logic [1:0]   in_tuser,
  // Results.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: index_a[15:0], index_b[31:16], index_c[47:32], tangent_x[63:48],
  //        tangent_y[79:64], tangent_z[95:80]
  output logic [95:0]       out_tdata
);

  // Mask that keeps the meaningful index bits.
  localparam logic [IDX_W-1:0] IDX_MASK =
    (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

  // Difference b - a of two signed 32-bit values.
  function automatic logic [32:0] sdiff(input logic [31:0] a, input logic [31:0] b);
    return {b[31], b} - {a[31], a};
  endfunction

  // Magnitude of a 33-bit signed difference.
  function automatic logic [31:0] smag(input logic [32:0] d);
    logic [32:0] n;
    n = d[32] ? (~d + 33'd1) : d;
    return n[31:0];
  endfunction

  ttu_state_t state_r, state_nxt;

  // Held corners and corner 2.
  logic [31:0]      hpos_r [0:5];
  logic [31:0]      huv_r  [0:3];
  logic [IDX_W-1:0] hidx_r [0:1];
  logic [31:0]      cpos_r [0:2];
  logic [31:0]      cuv_r  [0:1];
  logic [IDX_W-1:0] cidx_r;
  logic             enable_r;

  // Datapath registers.
  logic [2:0]  job_r;
  logic [5:0]  bitcnt_r;
  logic [1:0]  comp_r;
  logic [31:0] mcand_r;
  logic [63:0] prod_r;
  logic        psign_r;
  logic [65:0] acc_r;
  logic        det_neg_r;
  logic [64:0] cmag_r [0:2];
  logic        cneg_r [0:2];
  logic [63:0] sum_r;
  logic [63:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [45:0] dq_r;
  logic [32:0] rem_r;
  logic [15:0] tan_r [0:2];
  logic        out_valid_r;
  logic [95:0] out_data_r;

  logic [31:0] field_pos [0:2];
  logic [31:0] field_uv  [0:1];
  logic [1:0]  corner;
  logic        in_fire;

  // Slot of a held corner in the position and UV stores.
  logic [2:0]  wpos;
  logic [1:0]  wuv;

  assign corner       = in_tuser;
  assign field_pos[0] = in_tdata[47:16];
  assign field_pos[1] = in_tdata[79:48];
  assign field_pos[2] = in_tdata[111:80];
  assign field_uv[0]  = in_tdata[143:112];
  assign field_uv[1]  = in_tdata[175:144];
  assign wpos         = corner[0] ? 3'd3 : 3'd0;
  assign wuv          = {corner[0], 1'b0};

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Operand selection for the current product.
  logic [1:0]  lane;
  logic [2:0]  lane_lo, lane_hi;
  logic [31:0] da_a, da_b, db_a, db_b;
  logic [32:0] diff_a, diff_b;

  assign lane    = job_r[2:1] - 2'd1;
  assign lane_lo = {1'b0, lane};
  assign lane_hi = lane_lo + 3'd3;

  always_comb begin
    da_a = huv_r[1];
    da_b = cuv_r[1];
    db_a = hpos_r[lane_lo];
    db_b = hpos_r[lane_hi];
    case (job_r)
      3'd0: begin
        da_a = huv_r[0];
        da_b = huv_r[2];
        db_a = huv_r[1];
        db_b = cuv_r[1];
      end
      3'd1: begin
        da_a = huv_r[1];
        da_b = huv_r[3];
        db_a = huv_r[0];
        db_b = cuv_r[0];
      end
      default: begin
        if (job_r[0]) begin
          da_a = huv_r[1];
          da_b = huv_r[3];
          db_b = cpos_r[lane];
        end
      end
    endcase
  end

  assign diff_a = sdiff(da_a, da_b);
  assign diff_b = sdiff(db_a, db_b);

  // Shared helpers for the sequence.
  logic [32:0] mul_sum;
  logic [65:0] prod_signed;
  logic [64:0] comp_or;
  logic [63:0] sq_trial;
  logic [31:0] len;
  logic [32:0] div_sh;
  logic        div_ge;
  logic [15:0] q_clamp;

  assign mul_sum     = {1'b0, prod_r[63:32]} + (prod_r[0] ? {1'b0, mcand_r} : 33'd0);
  assign prod_signed = psign_r ? (~{2'b00, prod_r} + 66'd1) : {2'b00, prod_r};
  assign comp_or     = cmag_r[0] | cmag_r[1] | cmag_r[2];
  assign sq_trial    = sq_res_r + sq_bit_r;
  assign len         = sq_res_r[31:0];
  assign div_sh      = {rem_r[31:0], dq_r[45]};
  assign div_ge      = div_sh >= {1'b0, len};
  assign q_clamp     = (dq_r > 46'(ONE_Q14)) ? ONE_Q14 : dq_r[15:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && corner == CORNER_2 && enable_r) state_nxt = ST_MUL_LOAD;
      end
      ST_MUL_LOAD: state_nxt = ST_MUL_RUN;
      ST_MUL_RUN: begin
        if (bitcnt_r == 6'd31) state_nxt = ST_MUL_ACC;
      end
      ST_MUL_ACC: state_nxt = ST_MUL_NEXT;
      ST_MUL_NEXT: begin
        if (job_r == 3'd1 && acc_r == '0) state_nxt = ST_DONE;
        else if (job_r == 3'd7) state_nxt = ST_NORM;
        else state_nxt = ST_MUL_LOAD;
      end
      ST_NORM: begin
        if (comp_or == '0) state_nxt = ST_DONE;
        else if (comp_or[64:31] == '0) state_nxt = ST_SQ_LOAD;
      end
      ST_SQ_LOAD: state_nxt = ST_SQ_RUN;
      ST_SQ_RUN: begin
        if (bitcnt_r == 6'd31) state_nxt = ST_SQ_ACC;
      end
      ST_SQ_ACC: state_nxt = (comp_r == 2'd2) ? ST_SQRT_INIT : ST_SQ_LOAD;
      ST_SQRT_INIT: state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (sq_bit_r == 64'd1) state_nxt = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: state_nxt = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (bitcnt_r == 6'd45) state_nxt = ST_DIV_END;
      end
      ST_DIV_END: state_nxt = (comp_r == 2'd2) ? ST_DONE : ST_DIV_LOAD;
      ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Configuration and held corners.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      for (int i = 0; i < 6; i++) hpos_r[i] <= '0;
      for (int i = 0; i < 4; i++) huv_r[i] <= '0;
      hidx_r[0] <= '0;
      hidx_r[1] <= '0;
    end else begin
      if (cfg_valid) enable_r <= cfg_data;
      if (in_fire && (corner == CORNER_0 || corner == CORNER_1)) begin
        for (int i = 0; i < 3; i++) hpos_r[wpos + 3'(i)] <= field_pos[i];
        huv_r[wuv]          <= field_uv[0];
        huv_r[wuv | 2'd1]   <= field_uv[1];
        hidx_r[corner[0]]   <= in_tdata[15:0] & IDX_MASK;
      end
    end
  end

  // Output register; a transaction leaves it free for the next result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {tan_r[2], tan_r[1], tan_r[0], cidx_r, hidx_r[1], hidx_r[0]};
    end
  end

  // Arithmetic sequence.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire && corner == CORNER_2) begin
          for (int i = 0; i < 3; i++) cpos_r[i] <= field_pos[i];
          cuv_r[0] <= field_uv[0];
          cuv_r[1] <= field_uv[1];
          cidx_r   <= in_tdata[15:0] & IDX_MASK;
          job_r    <= 3'd0;
          for (int i = 0; i < 3; i++) tan_r[i] <= '0;
        end
      end
      ST_MUL_LOAD: begin
        mcand_r  <= smag(diff_a);
        prod_r   <= {32'd0, smag(diff_b)};
        psign_r  <= diff_a[32] ^ diff_b[32];
        bitcnt_r <= '0;
      end
      ST_MUL_RUN, ST_SQ_RUN: begin
        prod_r   <= {mul_sum, prod_r[31:1]};
        bitcnt_r <= bitcnt_r + 6'd1;
      end
      ST_MUL_ACC: begin
        acc_r <= job_r[0] ? (acc_r - prod_signed) : prod_signed;
      end
      ST_MUL_NEXT: begin
        if (job_r == 3'd1) det_neg_r <= acc_r[65];
        if (job_r[0] && job_r != 3'd1) begin
          cmag_r[lane] <= acc_r[65] ? 65'(~acc_r + 66'd1) : acc_r[64:0];
          cneg_r[lane] <= acc_r[65] ^ det_neg_r;
        end
        job_r  <= job_r + 3'd1;
        comp_r <= '0;
        sum_r  <= '0;
      end
      ST_NORM: begin
        if (comp_or[64:31] != '0) begin
          for (int i = 0; i < 3; i++) cmag_r[i] <= cmag_r[i] >> 1;
        end
      end
      ST_SQ_LOAD: begin
        mcand_r  <= {1'b0, cmag_r[comp_r][30:0]};
        prod_r   <= {33'd0, cmag_r[comp_r][30:0]};
        bitcnt_r <= '0;
      end
      ST_SQ_ACC: begin
        sum_r  <= sum_r + prod_r;
        comp_r <= comp_r + 2'd1;
      end
      ST_SQRT_INIT: begin
        sq_v_r   <= sum_r;
        sq_res_r <= '0;
        sq_bit_r <= 64'd1 << 62;
        comp_r   <= '0;
      end
      ST_SQRT: begin
        if (sq_v_r >= sq_trial) begin
          sq_v_r   <= sq_v_r - sq_trial;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      ST_DIV_LOAD: begin
        dq_r     <= {1'b0, cmag_r[comp_r][30:0], 14'd0} + {15'd0, len[31:1]};
        rem_r    <= '0;
        bitcnt_r <= '0;
      end
      ST_DIV_RUN: begin
        rem_r    <= div_ge ? (div_sh - {1'b0, len}) : div_sh;
        dq_r     <= {dq_r[44:0], div_ge};
        bitcnt_r <= bitcnt_r + 6'd1;
      end
      ST_DIV_END: begin
        tan_r[comp_r] <= cneg_r[comp_r] ? (~q_clamp + 16'd1) : q_clamp;
        comp_r        <= comp_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

endmodule : triangle_tangent_unit

`default_nettype wire
